[design/bmhq_pkg.sv]
// Package for the binary min-heap queue: payload structs, status codes,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing.
package bmhq_pkg;

    // Default number of heap entries.
    localparam int HqCapacity = 64;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Request codes.
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] key_in;
    } t_hq_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] extracted_key;
        logic [6:0]         entry_count;
        logic               min_valid;
        logic signed [31:0] current_min;
    } t_hq_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_LAST_RD,
        S_LAST_GET,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } t_hq_state;

    // Read address selection for the heap memory.
    typedef enum logic [1:0] {
        RD_PARENT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } t_hq_rd;

    typedef struct packed {
        logic   load_req;
        logic   set_empty;
        logic   set_full;
        logic   start_ins;
        logic   start_ext;
        t_hq_rd rd_sel;
        logic   wr_key;
        logic   up_swap;
        logic   take_last;
        logic   take_left;
        logic   dn_swap;
        logic   load_out;
    } t_hq_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic pos_zero;
        logic count_zero;
        logic up_less;
        logic left_in;
        logic dn_less;
        logic out_free;
    } t_hq_sts;

endpackage

[design/bmhq_dp.sv]
// Datapath of the binary min-heap queue: heap memory, entry count, sift
// position, moving key, root copy and the result register.
// Depends on bmhq_pkg.
module bmhq_dp #(
    parameter int CAPACITY = bmhq_pkg::HqCapacity
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmhq_pkg::t_hq_in  i_in_data,
    input  bmhq_pkg::t_hq_cmd i_cmd,
    output bmhq_pkg::t_hq_sts o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output bmhq_pkg::t_hq_out o_out_data
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    logic signed [31:0] r_heap [CAPACITY];
    logic signed [31:0] r_rd_data;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_pos;
    logic signed [31:0] r_key;
    logic signed [31:0] r_left;
    logic signed [31:0] r_root;
    logic signed [31:0] r_taken;
    logic [1:0]         r_status;
    logic               r_out_valid;
    t_hq_out            r_out;

    logic [AW-1:0]      parent;
    logic [XW-1:0]      left_x;
    logic [XW-1:0]      right_x;
    logic [XW-1:0]      count_x;
    logic               left_in;
    logic               right_in;
    logic               pick_right;
    logic signed [31:0] pick_val;
    logic [AW-1:0]      pick_idx;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic signed [31:0] wr_data;

    assign parent     = AW'((r_pos - 1'b1) >> 1);
    assign left_x     = {1'b0, r_pos, 1'b1};
    assign right_x    = left_x + 1'b1;
    assign count_x    = XW'(r_count);
    assign left_in    = left_x < count_x;
    assign right_in   = right_x < count_x;
    // Left child wins a tie; the right child counts only if it exists.
    assign pick_right = right_in && (r_rd_data < r_left);
    assign pick_val   = pick_right ? r_rd_data : r_left;
    assign pick_idx   = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PARENT: rd_addr = parent;
            RD_LAST:   rd_addr = r_count[AW-1:0];
            RD_LEFT:   rd_addr = left_x[AW-1:0];
            RD_RIGHT:  rd_addr = right_in ? right_x[AW-1:0] : left_x[AW-1:0];
            default:   rd_addr = parent;
        endcase
    end

    assign wr_en   = i_cmd.wr_key | i_cmd.up_swap | i_cmd.dn_swap;
    assign wr_data = i_cmd.wr_key  ? r_key :
                     i_cmd.up_swap ? r_rd_data : pick_val;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap[r_pos] <= wr_data;
        end
        r_rd_data <= r_heap[rd_addr];
    end

    // Entry count and result valid are the only control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_ins) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.start_ext) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_key    <= i_in_data.key_in;
            r_status <= i_cmd.set_full  ? STAT_FULL :
                        i_cmd.set_empty ? STAT_EMPTY : STAT_OK;
        end
        if (i_cmd.start_ext) begin
            r_taken <= r_root;
        end else if (i_cmd.load_req) begin
            r_taken <= '0;
        end
        if (i_cmd.start_ins) begin
            r_pos <= r_count[AW-1:0];
        end else if (i_cmd.take_last) begin
            r_pos <= '0;
        end else if (i_cmd.up_swap) begin
            r_pos <= parent;
        end else if (i_cmd.dn_swap) begin
            r_pos <= pick_idx;
        end
        if (i_cmd.take_last) begin
            r_key <= r_rd_data;
        end
        if (i_cmd.take_left) begin
            r_left <= r_rd_data;
        end
        // The root is mirrored so the current minimum needs no memory read.
        if (wr_en && (r_pos == '0)) begin
            r_root <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status        <= r_status;
            r_out.extracted_key <= r_taken;
            r_out.entry_count   <= 7'(r_count);
            r_out.min_valid     <= (r_count != '0);
            r_out.current_min   <= (r_count != '0) ? r_root : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count == CapCount);
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.up_less    = (r_key < r_rd_data);
    assign o_sts.left_in    = left_in;
    assign o_sts.dn_less    = (pick_val < r_key);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapCount)
        else $error("entry count exceeds capacity");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (XW'(r_pos) < count_x))
        else $error("heap write outside the occupied entries");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.start_ins && !i_cmd.start_ext) |=> (r_count == $past(r_count)))
        else $error("entry count changed without a transaction starting");
`endif

endmodule

[design/bmhq_ctrl.sv]
// Controller of the binary min-heap queue: state machine that sequences
// request decode, sift-up, sift-down and result hand-off.
// Depends on bmhq_pkg.
module bmhq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_ready,
    input  bmhq_pkg::t_hq_sts i_sts,
    output bmhq_pkg::t_hq_cmd o_cmd
);
    import bmhq_pkg::*;

    t_hq_state r_state;
    t_hq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_PARENT;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (i_req_type == REQ_INSERT) begin
                        if (i_sts.full) begin
                            o_cmd.set_full = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.start_ins = 1'b1;
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            o_cmd.set_empty = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.start_ext = 1'b1;
                            n_state = S_LAST_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                o_cmd.rd_sel = RD_PARENT;
                if (i_sts.pos_zero) begin
                    o_cmd.wr_key = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_less) begin
                    o_cmd.up_swap = 1'b1;
                    n_state = S_UP_RD;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_LAST_RD: begin
                o_cmd.rd_sel = RD_LAST;
                n_state = i_sts.count_zero ? S_DONE : S_LAST_GET;
            end
            S_LAST_GET: begin
                o_cmd.take_last = 1'b1;
                n_state = S_DN_RDL;
            end
            S_DN_RDL: begin
                o_cmd.rd_sel = RD_LEFT;
                if (!i_sts.left_in) begin
                    o_cmd.wr_key = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                o_cmd.take_left = 1'b1;
                o_cmd.rd_sel = RD_RIGHT;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_sts.dn_less) begin
                    o_cmd.dn_swap = 1'b1;
                    n_state = S_DN_RDL;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("controller idle right after accepting a transaction");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_sts.out_free) |=> (r_state == S_DONE))
        else $error("result dropped while the output register was full");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result register overwritten");
`endif

endmodule

[design/binary_min_heap_queue.sv]
// Top level of the binary min-heap priority queue of signed 32-bit keys.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_dp.
//
// Usage: each input transaction is a request, either insert key_in or extract
// the minimum. Every request yields exactly one output transaction that carries
// a status, the extracted key, the entry count, and the new minimum.
// An extract on an empty heap reports the empty status; an insert into a full
// heap drops the key and reports the full status.
//
// Timing: one request at a time. The next request is accepted in the cycle after the result
// turns valid at the earliest. Rejected requests go straight to the result. An insert reads the
// parent and compares at each level that it climbs, and writes the key where it stops. An extract
// first reads the last entry as the key to move down from the root, then at each level that it
// descends reads the children and compares; an extract that empties the heap skips the descent.
// Each level needs a registered read of a parent or both children.
//
// Reset clears the entry count, the controller and the result valid; the
// heap memory itself is left as is, since entries at or above the count are
// never used. The result sits in an output register: while the receiver
// stalls, the block finishes its current request and then holds it until the
// register is free, and accepts no new request in the meantime.
module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::HqCapacity
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bmhq_pkg::t_hq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bmhq_pkg::t_hq_out o_out_data
);
    import bmhq_pkg::*;

    // Command and status structs are the only link between the two halves.
    t_hq_cmd cmd;
    t_hq_sts sts;

    bmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[test/binary_min_heap_queue_tb.sv]
// Self-checking testbench for binary_min_heap_queue: directed requests from a table, then
// random insert and extract bursts, each result checked against a shadow min-heap or a typed-in result.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.
module binary_min_heap_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int HEAP_DEPTH      = HqCapacity;
    localparam int RANDOM_ITEMS    = 1950;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;

    // Burst flavors for the random part.
    localparam int MIX_FILL     = 0;
    localparam int MIX_DRAIN    = 1;
    localparam int MIX_BALANCED = 2;

    // Key flavors: full 32-bit range, a narrow band that forces ties, and corner values.
    localparam int KEYS_WIDE    = 0;
    localparam int KEYS_NARROW  = 1;
    localparam int KEYS_CORNERS = 2;

    // One row of the directed table. A pinned row carries a result typed in by hand;
    // all other rows are checked against the shadow heap.
    typedef struct {
        t_hq_in  req;
        bit      pinned;
        t_hq_out result;
    } t_stim_row;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    t_hq_in  i_in_data   = '0;
    logic    i_out_ready = 1'b0;
    logic    o_in_ready;
    logic    o_out_valid;
    t_hq_out o_out_data;

    // Hand-written result that travels along with the request currently offered.
    bit      pin_valid  = 1'b0;
    t_hq_out pin_result = '0;

    // Shadow copy of the heap, updated once per accepted request.
    logic signed [31:0] shadow_keys [HEAP_DEPTH];
    int                 shadow_fill = 0;

    t_hq_out   pending_results [$];
    t_stim_row stim_rows [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int idle_pct      = 10;
    int random_sent   = 0;
    bit stall_request = 1'b0;

    binary_min_heap_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one request to the shadow heap and returns the result the block must give.
    // Sift-up swaps only while strictly smaller than the parent; sift-down takes the
    // smaller child, the left one on a tie, and only looks at children below the count.
    function automatic t_hq_out heap_request_result(input t_hq_in req);
        t_hq_out            res;
        int                 pos;
        int                 parent;
        int                 left;
        int                 right;
        int                 pick;
        bit                 moving;
        logic signed [31:0] tmp;
        res = '0;
        res.status = STAT_OK;
        if (req.req_type == REQ_EXTRACT) begin
            if (shadow_fill == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.extracted_key = shadow_keys[0];
                shadow_fill--;
                shadow_keys[0] = shadow_keys[shadow_fill];
                pos = 0;
                moving = 1'b1;
                while (moving) begin
                    left = 2 * pos + 1;
                    right = left + 1;
                    if (left >= shadow_fill) begin
                        moving = 1'b0;
                    end else begin
                        pick = left;
                        if (right < shadow_fill && shadow_keys[right] < shadow_keys[left]) begin
                            pick = right;
                        end
                        if (shadow_keys[pick] < shadow_keys[pos]) begin
                            tmp = shadow_keys[pos];
                            shadow_keys[pos] = shadow_keys[pick];
                            shadow_keys[pick] = tmp;
                            pos = pick;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end
        end else if (shadow_fill >= HEAP_DEPTH) begin
            // A full heap drops the key and reports the unchanged contents.
            res.status = STAT_FULL;
        end else begin
            pos = shadow_fill;
            shadow_keys[pos] = req.key_in;
            shadow_fill++;
            moving = 1'b1;
            while (moving && pos > 0) begin
                parent = (pos - 1) / 2;
                if (shadow_keys[pos] < shadow_keys[parent]) begin
                    tmp = shadow_keys[pos];
                    shadow_keys[pos] = shadow_keys[parent];
                    shadow_keys[parent] = tmp;
                    pos = parent;
                end else begin
                    moving = 1'b0;
                end
            end
        end
        res.entry_count = 7'(shadow_fill);
        res.min_valid = (shadow_fill > 0);
        res.current_min = (shadow_fill > 0) ? shadow_keys[0] : '0;
        return res;
    endfunction

    function automatic void check_result(input t_hq_out want, input t_hq_out got);
        if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            error_count++;
        end
        if (got.extracted_key !== want.extracted_key) begin
            $error("extracted_key mismatch: expected %0d, actual %0d",
                   want.extracted_key, got.extracted_key);
            error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   want.entry_count, got.entry_count);
            error_count++;
        end
        if (got.min_valid !== want.min_valid) begin
            $error("min_valid mismatch: expected %0d, actual %0d",
                   want.min_valid, got.min_valid);
            error_count++;
        end
        if (got.current_min !== want.current_min) begin
            $error("current_min mismatch: expected %0d, actual %0d",
                   want.current_min, got.current_min);
            error_count++;
        end
    endfunction

    // Both channels are sampled at the rising edge, before the block's own registers
    // move. The result side is handled first, so that a result arriving with nothing
    // waiting is caught even when a new request is accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    error_count++;
                end else begin
                    check_result(pending_results.pop_front(), o_out_data);
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (pin_valid) begin
                    // Keep the shadow heap in step even when the result is typed in.
                    void'(heap_request_result(i_in_data));
                    pending_results.push_back(pin_result);
                end else begin
                    pending_results.push_back(heap_request_result(i_in_data));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: drops ready at random, except while a long hold-off has been asked for.
    // During the hold-off the sender keeps offering requests, so the block finishes
    // the one in hand, parks its result and then refuses further input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                stall_request = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    function automatic void add_row(input logic req_type, input logic signed [31:0] key,
                                    input bit pinned, input logic [1:0] status,
                                    input logic signed [31:0] taken, input int count,
                                    input logic signed [31:0] root);
        t_stim_row row;
        row.req.req_type = req_type;
        row.req.key_in = key;
        row.pinned = pinned;
        row.result.status = status;
        row.result.extracted_key = taken;
        row.result.entry_count = 7'(count);
        row.result.min_valid = (count > 0);
        row.result.current_min = root;
        stim_rows.push_back(row);
    endfunction

    // Offers one request from the next falling edge on and returns once it is accepted.
    // Valid is left high, so a following request keeps it up without a dip.
    task automatic send_request(input t_hq_in req, input bit pinned, input t_hq_out result);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= req;
        pin_valid <= pinned;
        pin_result <= result;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
    endtask

    // Occasional gap on the request side, during which valid is low.
    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    endtask

    // Stops offering requests until every outstanding result has been taken.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] draw_key(input int flavor);
        logic signed [31:0] k;
        k = $urandom;
        if (flavor == KEYS_NARROW) begin
            k = $urandom_range(0, 15);
            k = k - 8;
        end else if (flavor == KEYS_CORNERS) begin
            case ($urandom_range(0, 4))
                0: k = 32'sh7FFFFFFF;
                1: k = 32'sh80000000;
                2: k = '0;
                3: k = -32'sd1;
                default: k = $urandom;
            endcase
        end
        return k;
    endfunction

    task automatic send_random(input logic req_type, input int flavor);
        t_hq_in req;
        req.req_type = req_type;
        // The key is random on extracts too, where the block must ignore it.
        req.key_in = draw_key(flavor);
        sender_gap();
        send_request(req, 1'b0, '0);
        random_sent++;
        // A long receiver hold-off while requests keep coming.
        if (random_sent == 400) begin
            stall_request = 1'b1;
        end
        // A full pause on the request side until the queue of results is empty.
        if (random_sent == 1000) begin
            wait_for_drain();
        end
        // A long stretch without idling on either side.
        idle_pct = (random_sent >= 1200 && random_sent < 1500) ? 0 : 10;
    endtask

    initial begin
        int      burst_len;
        int      mix;
        int      flavor;
        int      extract_pct;

        // Directed table. Extracts from an empty heap, the first inserts, the first extract that
        // succeeds and the extract that empties the heap are typed in; the rest use the shadow heap.
        add_row(REQ_EXTRACT, 32'sd0,          1'b1, STAT_EMPTY, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, -32'sd1,         1'b1, STAT_EMPTY, 32'sd0, 0, 32'sd0);
        add_row(REQ_INSERT,  32'sh7FFFFFFF,   1'b1, STAT_OK, 32'sd0, 1, 32'sh7FFFFFFF);
        add_row(REQ_INSERT,  32'sh80000000,   1'b1, STAT_OK, 32'sd0, 2, 32'sh80000000);
        add_row(REQ_INSERT,  32'sd0,          1'b1, STAT_OK, 32'sd0, 3, 32'sh80000000);
        add_row(REQ_INSERT,  -32'sd1,         1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        // Equal keys must never swap.
        add_row(REQ_INSERT,  32'sd5,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_INSERT,  32'sd5,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_INSERT,  32'sd5,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sh12345678,   1'b1, STAT_OK, 32'sh80000000, 6, -32'sd1);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, -32'sd1,         1'b1, STAT_OK, 32'sh7FFFFFFF, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b1, STAT_EMPTY, 32'sd0, 0, 32'sd0);
        // Ties in sift-down, where a child equal to the moved key must not swap with it.
        add_row(REQ_INSERT,  32'sd3,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_INSERT,  32'sd3,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_INSERT,  32'sd1,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_INSERT,  32'sd2,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);
        add_row(REQ_EXTRACT, 32'sd0,          1'b0, STAT_OK, 32'sd0, 0, 32'sd0);

        // Synchronous reset, released at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            sender_gap();
            send_request(stim_rows[r].req, stim_rows[r].pinned, stim_rows[r].result);
        end
        wait_for_drain();

        // Fill past capacity so that inserts are dropped, then empty it past zero.
        repeat (HEAP_DEPTH + 6) send_random(REQ_INSERT, KEYS_WIDE);
        repeat (HEAP_DEPTH + 6) send_random(REQ_EXTRACT, KEYS_WIDE);

        // Bursts with a bias toward growing, shrinking or holding the heap size, so
        // that the fill level sweeps the whole range and both rejections recur.
        while (random_sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(20, 80);
            mix = $urandom_range(MIX_FILL, MIX_BALANCED);
            flavor = $urandom_range(KEYS_WIDE, KEYS_CORNERS);
            extract_pct = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 85 : 50;
            repeat (burst_len) begin
                send_random(($urandom_range(99) < extract_pct) ? REQ_EXTRACT : REQ_INSERT,
                            flavor);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
